// ===== hw/rtl/tlst_pkg.sv =====
`timescale 1ns / 1ps
package tlst_pkg;

   localparam int unsigned TICKS_PER_REV_DEF = 1536000;
   localparam int unsigned TICKS_W           = 24;
   localparam logic [31:0] PI_Q30            = 32'd3373259426;

   localparam int unsigned LEN_W   = 24;
   localparam int unsigned DIST_W  = 24;
   localparam int unsigned TICK_W  = 32;
   localparam int unsigned CSR_W   = 16;

   localparam int unsigned C0_W    = 23;
   localparam int unsigned MAG_W   = 30;
   localparam int unsigned DISC_W  = 51;
   localparam int unsigned SQIN_W  = 64;
   localparam int unsigned ROOT_W  = 32;
   localparam int unsigned DEN_W   = 33;
   localparam int unsigned NUM_W   = 69;
   localparam int unsigned QUO_W   = 57;
   localparam int unsigned TURN_W  = 59;

   typedef enum logic {
      CSR_CIRC  = 1'b0,
      CSR_THICK = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TA,
      ST_LO,
      ST_HI,
      ST_CC,
      ST_SQ,
      ST_SQW,
      ST_DIV,
      ST_DVW,
      ST_ML,
      ST_MH,
      ST_FIN,
      ST_OUT
   } state_type;

endpackage

// ===== hw/rtl/tlst_req_if.sv =====
`timescale 1ns / 1ps
interface tlst_req_if;
   import tlst_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [LEN_W-1:0]   current_length;
   logic        [DIST_W-1:0]  move_distance;
   logic                      direction;

   modport source (output valid, current_length, move_distance, direction, input ready);
   modport sink   (input valid, current_length, move_distance, direction, output ready);
endinterface

// ===== hw/rtl/tlst_rsp_if.sv =====
`timescale 1ns / 1ps
interface tlst_rsp_if;
   import tlst_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [TICK_W-1:0]  tick_count;
   logic                      saturated;
   logic                      status;

   modport source (output valid, tick_count, saturated, status, input ready);
   modport sink   (input valid, tick_count, saturated, status, output ready);
endinterface

// ===== hw/rtl/tape_length_to_step_ticks.sv =====
`timescale 1ns / 1ps
// Converts a tape move into signed stepper ticks through the drum model
// L = C0*n + pi*t*n^2. One move is worked at a time: req ready is low from
// the transfer until the result has been taken. A move with nonzero
// distance and nonzero circumference makes two passes (target, then
// current length) through a 32-step square root and a 69-step restoring
// divider, with the other products on one shared 32x32 multiplier. A zero
// distance or zero circumference answers in the cycle after the transfer.
module tape_length_to_step_ticks import tlst_pkg::*; #(
   parameter int unsigned TICKS_PER_REV = TICKS_PER_REV_DEF
) (
   input  logic              clock,
   input  logic              reset,
   tlst_req_if.sink          req_ch,
   tlst_rsp_if.source        rsp_ch,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   localparam logic [31:0] TICKS_OP = 32'(TICKS_PER_REV);

   state_type state_ff, state_in;

   logic [CSR_W-1:0]        circ_ff;
   logic [CSR_W-1:0]        thick_ff;
   logic signed [31:0]      cur_um_ff;
   logic signed [31:0]      tar_um_ff;
   logic [C0_W-1:0]         c0_ff;
   logic                    pass_ff;
   logic [13:0]             ta_hi_ff;
   logic [DISC_W-1:0]       acc_ff;
   logic signed [TURN_W-1:0] turn0_ff;
   logic [TURN_W-1:0]       m_ff;
   logic                    dneg_ff;
   logic [24:0]             lowr_ff;
   logic [63:0]             prod_ff;
   logic signed [TICK_W-1:0] tick_ff;
   logic                    sat_ff;
   logic                    status_ff;

   logic [31:0]             mul_a;
   logic [31:0]             mul_b;
   logic                    sq_start;
   logic                    dv_start;
   logic [ROOT_W-1:0]       sq_root;
   logic                    sq_done;
   logic [QUO_W-1:0]        dv_quo;
   logic                    dv_done;

   logic signed [31:0]      len_w;
   logic                    neg_w;
   logic [MAG_W-1:0]        a_w;
   logic signed [31:0]      cur_um_w;
   logic signed [31:0]      dist_um_w;
   logic signed [TURN_W-1:0] turn_w;
   logic signed [TURN_W:0]  dn_w;
   logic [51:0]             mag_w;
   logic                    accept_w;

   assign accept_w  = req_ch.valid && req_ch.ready;
   assign cur_um_w  = 32'(req_ch.current_length) * 32'sd100;
   assign dist_um_w = $signed({8'd0, req_ch.move_distance}) * 32'sd10;

   assign len_w = pass_ff ? cur_um_ff : tar_um_ff;
   assign neg_w = len_w[31];
   assign a_w   = neg_w ? MAG_W'(-len_w) : MAG_W'(len_w);

   assign turn_w = neg_w ? -$signed({2'b00, dv_quo}) : $signed({2'b00, dv_quo});
   assign dn_w   = {turn0_ff[TURN_W-1], turn0_ff} - {turn_w[TURN_W-1], turn_w};
   assign mag_w  = prod_ff[51:0] + {27'd0, lowr_ff};

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         circ_ff  <= '0;
         thick_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CIRC:  circ_ff  <= csr_wdata;
            CSR_THICK: thick_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.move_distance == '0 || circ_ff == '0) state_in = ST_OUT;
               else state_in = ST_TA;
            end
         end
         ST_TA:  state_in = ST_LO;
         ST_LO:  state_in = ST_HI;
         ST_HI:  state_in = ST_CC;
         ST_CC:  state_in = ST_SQ;
         ST_SQ:  state_in = ST_SQW;
         ST_SQW: if (sq_done) state_in = ST_DIV;
         ST_DIV: state_in = ST_DVW;
         ST_DVW: begin
            if (dv_done) state_in = pass_ff ? ST_ML : ST_TA;
         end
         ST_ML:  state_in = ST_MH;
         ST_MH:  state_in = ST_FIN;
         ST_FIN: state_in = ST_OUT;
         ST_OUT: if (rsp_ch.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      sq_start = 1'b0;
      dv_start = 1'b0;
      case (state_ff)
         ST_TA: begin
            mul_a = {2'b00, a_w};
            mul_b = {16'd0, thick_ff};
         end
         ST_LO: begin
            mul_a = PI_Q30;
            mul_b = prod_ff[31:0];
         end
         ST_HI: begin
            mul_a = PI_Q30;
            mul_b = {18'd0, ta_hi_ff};
         end
         ST_CC: begin
            mul_a = {9'd0, c0_ff};
            mul_b = {9'd0, c0_ff};
         end
         ST_SQ:  sq_start = 1'b1;
         ST_DIV: dv_start = 1'b1;
         ST_ML: begin
            mul_a = m_ff[31:0];
            mul_b = TICKS_OP;
         end
         ST_MH: begin
            mul_a = {5'd0, m_ff[TURN_W-1:32]};
            mul_b = TICKS_OP;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // shared multiplier
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept_w) begin
               cur_um_ff <= cur_um_w;
               tar_um_ff <= req_ch.direction ? cur_um_w - dist_um_w : cur_um_w + dist_um_w;
               c0_ff     <= C0_W'(circ_ff * 23'd100);
               pass_ff   <= 1'b0;
               tick_ff   <= '0;
               sat_ff    <= 1'b0;
               status_ff <= (req_ch.move_distance != '0) && (circ_ff == '0);
            end
         end
         ST_LO: ta_hi_ff <= prod_ff[45:32];
         ST_HI: acc_ff   <= {15'd0, prod_ff[63:28]};
         ST_CC: acc_ff   <= acc_ff + {1'b0, prod_ff[45:0], 4'd0};
         ST_DVW: begin
            if (dv_done) begin
               if (!pass_ff) begin
                  turn0_ff <= turn_w;
                  pass_ff  <= 1'b1;
               end else begin
                  dneg_ff <= dn_w[TURN_W];
                  m_ff    <= dn_w[TURN_W] ? TURN_W'(-dn_w) : TURN_W'(dn_w);
               end
            end
         end
         ST_MH: lowr_ff <= 25'((prod_ff + 64'h8000_0000) >> 32);
         ST_FIN: begin
            if (!dneg_ff) begin
               if (mag_w > 52'h7FFF_FFFF) begin
                  tick_ff <= 32'sh7FFF_FFFF;
                  sat_ff  <= 1'b1;
               end else begin
                  tick_ff <= $signed(mag_w[31:0]);
               end
            end else begin
               if (mag_w > 52'h8000_0000) begin
                  tick_ff <= $signed(32'h8000_0000);
                  sat_ff  <= 1'b1;
               end else begin
                  tick_ff <= $signed(32'd0 - mag_w[31:0]);
               end
            end
         end
         default: ;
      endcase
   end

   tlst_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value ({1'b0, acc_ff + {5'd0, prod_ff[45:0]}, 12'd0}),
      .root  (sq_root),
      .done  (sq_done)
   );

   tlst_div u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .num   ({a_w, 39'd0}),
      .den   ({c0_ff, 6'd0} + {1'b0, sq_root}),
      .quo   (dv_quo),
      .done  (dv_done)
   );

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = (state_ff == ST_OUT);
   assign rsp_ch.tick_count = tick_ff;
   assign rsp_ch.saturated  = sat_ff;
   assign rsp_ch.status     = status_ff;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("transfer taken while busy");

   a_status_no_move: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status |-> rsp_ch.tick_count == '0 && !rsp_ch.saturated)
      else $error("error status with nonzero move");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.saturated |->
         rsp_ch.tick_count == 32'sh7FFF_FFFF || rsp_ch.tick_count == $signed(32'h8000_0000))
      else $error("saturated flag without clamped count");

endmodule

// ===== hw/rtl/tlst_isqrt.sv =====
`timescale 1ns / 1ps
module tlst_isqrt import tlst_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQIN_W-1:0] value,
   output logic [ROOT_W-1:0] root,
   output logic              done
);

   logic [SQIN_W-1:0]   val_ff;
   logic [ROOT_W+1:0]   rem_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [4:0]          cnt_ff;
   logic                busy_ff;
   logic                done_ff;

   logic [ROOT_W+3:0]   rem_in;
   logic [ROOT_W+3:0]   trial_in;
   logic                ge_in;

   assign rem_in   = {rem_ff, val_ff[SQIN_W-1 -: 2]};
   assign trial_in = {2'b00, root_ff, 2'b01};
   assign ge_in    = rem_in >= trial_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 5'd0);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 5'd0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         val_ff  <= value;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= 5'd31;
      end else if (busy_ff) begin
         val_ff <= {val_ff[SQIN_W-3:0], 2'b00};
         cnt_ff <= cnt_ff - 5'd1;
         if (ge_in) begin
            rem_ff  <= (ROOT_W+2)'(rem_in - trial_in);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_in[ROOT_W+1:0];
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

// ===== hw/rtl/tlst_div.sv =====
`timescale 1ns / 1ps
module tlst_div import tlst_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo,
   output logic             done
);

   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [6:0]       cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0]   part_in;
   logic             ge_in;

   assign part_in = {rem_ff, quo_ff[NUM_W-1]};
   assign ge_in   = part_in >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 7'd0);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 7'd0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
         cnt_ff <= 7'(NUM_W - 1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 7'd1;
         quo_ff <= {quo_ff[NUM_W-2:0], ge_in};
         if (ge_in) begin
            rem_ff <= DEN_W'(part_in - {1'b0, den_ff});
         end else begin
            rem_ff <= part_in[DEN_W-1:0];
         end
      end
   end

   assign quo  = quo_ff[QUO_W-1:0];
   assign done = done_ff;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import tlst_pkg::*;

   typedef struct packed {
      logic signed [TICK_W-1:0] tick_count;
      logic                     saturated;
      logic                     status;
   } move_result_type;

   logic             clock;
   logic             reset;
   logic             csr_we;
   csr_index_type    csr_index;
   logic [CSR_W-1:0] csr_wdata;

   tlst_req_if req_ch ();
   tlst_rsp_if rsp_ch ();

   tape_length_to_step_ticks DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   move_result_type tick_results_q[$];
   bit [15:0]    circ_model;
   bit [15:0]    thick_model;
   int           errors;
   bit           quiet;
   int           rsp_hold;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #24000000;
      $display("FAILURE");
      $finish;
   end

   // integer square root, bit-serial
   function automatic bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] res;
      bit [63:0] b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v   = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic bit [63:0] turn_magnitude(bit [63:0] a, bit [63:0] c0, bit [63:0] t);
      bit [63:0]  prod;
      bit [127:0] wide;
      bit [63:0]  quad;
      bit [63:0]  disc;
      bit [63:0]  root;
      bit [63:0]  den;
      bit [63:0]  num;
      bit [63:0]  q;
      bit [63:0]  rem;
      bit [63:0]  shifted;
      bit [63:0]  frac;
      prod    = t * a;
      wide    = {64'd0, prod} * 128'(PI_Q30);
      quad    = wide[91:28];
      disc    = c0 * c0 + quad;
      root    = int_sqrt(disc << 12);
      den     = (c0 << 6) + root;
      num     = a << 7;
      q       = num / den;
      rem     = num % den;
      shifted = rem << 32;
      frac    = shifted / den;
      return (q << 32) + frac;
   endfunction

   function automatic longint signed_turns(longint len, bit [63:0] c0, bit [63:0] t);
      if (len == 0) return 0;
      if (len > 0) return longint'(turn_magnitude(64'(len), c0, t));
      return -longint'(turn_magnitude(64'(-len), c0, t));
   endfunction

   function automatic move_result_type predict_ticks(logic signed [LEN_W-1:0] cur,
                                                     logic [DIST_W-1:0] move_dist, logic up);
      move_result_type r;
      longint       cur_um;
      longint       tar_um;
      longint       dn;
      bit [63:0]    m;
      bit [63:0]    mag;
      r = '0;
      if (move_dist != 0) begin
         if (circ_model == 0) begin
            r.status = 1'b1;
         end else begin
            cur_um = longint'(cur) * 100;
            tar_um = up ? cur_um - longint'(move_dist) * 10
                        : cur_um + longint'(move_dist) * 10;
            dn = signed_turns(tar_um, 64'(circ_model) * 100, 64'(thick_model))
               - signed_turns(cur_um, 64'(circ_model) * 100, 64'(thick_model));
            m   = (dn < 0) ? 64'(-dn) : 64'(dn);
            mag = (m >> 32) * 64'(TICKS_PER_REV_DEF)
                + (((m & 64'hFFFF_FFFF) * 64'(TICKS_PER_REV_DEF) + 64'h8000_0000) >> 32);
            if (dn >= 0) begin
               if (mag > 64'h7FFF_FFFF) begin
                  mag = 64'h7FFF_FFFF;
                  r.saturated = 1'b1;
               end
               r.tick_count = mag[31:0];
            end else begin
               if (mag > 64'h8000_0000) begin
                  mag = 64'h8000_0000;
                  r.saturated = 1'b1;
               end
               r.tick_count = 32'd0 - mag[31:0];
            end
         end
      end
      return r;
   endfunction

   // result receiver: random stall bursts plus long commanded holds
   initial begin
      int burst;
      burst = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ch.ready <= 1'b0;
         end else if (burst > 0) begin
            burst--;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 7) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      move_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (tick_results_q.size() == 0) begin
            $display("%0t: unexpected result tick_count=%0d", $time, rsp_ch.tick_count);
            errors++;
         end else begin
            want = tick_results_q.pop_front();
            if (rsp_ch.tick_count !== want.tick_count) begin
               $display("%0t: tick_count expected %0d actual %0d", $time,
                        want.tick_count, rsp_ch.tick_count);
               errors++;
            end
            if (rsp_ch.saturated !== want.saturated) begin
               $display("%0t: saturated expected %0b actual %0b", $time,
                        want.saturated, rsp_ch.saturated);
               errors++;
            end
            if (rsp_ch.status !== want.status) begin
               $display("%0t: status expected %0b actual %0b", $time,
                        want.status, rsp_ch.status);
               errors++;
            end
         end
      end
   end

   // valid stays high after a transfer until the next call or hold_sender
   task automatic send_move(logic signed [LEN_W-1:0] cur, logic [DIST_W-1:0] move_dist,
                            logic up);
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.current_length <= cur;
      req_ch.move_distance  <= move_dist;
      req_ch.direction      <= up;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tick_results_q.push_back(predict_ticks(cur, move_dist, up));
   endtask

   task automatic hold_sender();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      hold_sender();
      while (tick_results_q.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_CIRC) circ_model = value;
      else thick_model = value;
   endtask

   task automatic set_drum(logic [15:0] c0, logic [15:0] t);
      wait_drained();
      write_csr(CSR_CIRC, c0);
      write_csr(CSR_THICK, t);
   endtask

   task automatic send_random_move(int style);
      logic signed [LEN_W-1:0] cur;
      logic [DIST_W-1:0]       move_dist;
      cur       = LEN_W'($urandom());
      move_dist = DIST_W'($urandom());
      if (style == 0) begin
         cur       = $signed(24'($urandom_range(0, 200000))) - 24'sd100000;
         move_dist = DIST_W'($urandom_range(1, 100000));
      end else if (style == 1) begin
         move_dist = DIST_W'($urandom_range(0, 3));
      end
      send_move(cur, move_dist, 1'($urandom_range(0, 1)));
   endtask

   task automatic test_reset_defaults();
      send_move(24'sd1000, 24'd500, 1'b0);
      send_move(-24'sd8388608, 24'd0, 1'b1);
      send_move(24'sd0, 24'hFFFFFF, 1'b1);
   endtask

   task automatic test_directed();
      set_drum(16'd1000, 16'd0);
      send_move(24'sd0, 24'd1000, 1'b0);
      send_move(24'sd0, 24'd1000, 1'b1);
      send_move(24'sd500, 24'd0, 1'b0);
      send_move(24'sd100, 24'd1000, 1'b1);
      send_move(24'sd8388607, 24'hFFFFFF, 1'b0);
      send_move(-24'sd8388608, 24'hFFFFFF, 1'b1);
      set_drum(16'd65535, 16'd65535);
      send_move(24'sd8388607, 24'hFFFFFF, 1'b1);
      send_move(-24'sd8388608, 24'hFFFFFF, 1'b0);
      send_move(24'sd1, 24'd1, 1'b0);
      send_move(-24'sd1, 24'd10, 1'b0);
      set_drum(16'd1, 16'd0);
      send_move(24'sd0, 24'hFFFFFF, 1'b0);
      send_move(24'sd0, 24'hFFFFFF, 1'b1);
      send_move(24'sd8388607, 24'hFFFFFF, 1'b1);
      set_drum(16'd1, 16'd65535);
      send_move(-24'sd8388608, 24'hFFFFFF, 1'b0);
      send_move(24'sd8388607, 24'd1, 1'b1);
      set_drum(16'd0, 16'd300);
      send_move(24'sd4000, 24'd7, 1'b0);
      send_move(24'sd4000, 24'd0, 1'b1);
   endtask

   task automatic test_backpressure();
      set_drum(16'd3000, 16'd50);
      rsp_hold = 300;
      repeat (4) send_random_move(0);
      wait_drained();
   endtask

   task automatic test_random(int phases, int per_phase);
      logic [15:0] c0;
      logic [15:0] t;
      for (int p = 0; p < phases; p++) begin
         case ($urandom_range(0, 4))
            0: c0 = 16'd65535;
            1: c0 = 16'($urandom_range(1, 4));
            2: c0 = 16'd0;
            default: c0 = 16'($urandom());
         endcase
         case ($urandom_range(0, 3))
            0: t = 16'd0;
            1: t = 16'd65535;
            default: t = 16'($urandom_range(0, 500));
         endcase
         set_drum(c0, t);
         for (int i = 0; i < per_phase; i++) send_random_move($urandom_range(0, 5));
      end
   endtask

   initial begin
      errors       = 0;
      quiet        = 1'b0;
      rsp_hold     = 0;
      circ_model   = '0;
      thick_model  = '0;
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = CSR_CIRC;
      csr_wdata    = '0;
      req_ch.valid = 1'b0;
      req_ch.current_length = '0;
      req_ch.move_distance  = '0;
      req_ch.direction      = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed();
      test_backpressure();
      test_random(16, 50);
      quiet = 1'b1;
      test_random(2, 50);

      wait_drained();
      repeat (300) @(posedge clock);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
